FILE: sv/vkdd_pkg.sv
// Shared types, constants and register indexes for the volume key debounce decoder.
package vkdd_pkg;

  localparam int unsigned PORT_WIDTH = 8;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;

  // Only the low PORT_WIDTH bits of the port are wired to keys.
  localparam logic [DATA_W-1:0] PortMask =
      (PORT_WIDTH >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((1 << PORT_WIDTH) - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_MASK  = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_CODE_REL  = 3'd2,
    REG_CODE_UP   = 3'd3,
    REG_CODE_DOWN = 3'd4,
    REG_CODE_BOTH = 3'd5,
    REG_MAX_VOL   = 3'd6,
    REG_UNUSED    = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_UP    = 2'd1,
    EV_DOWN  = 2'd2,
    EV_ALBUM = 2'd3
  } key_event_e;

  typedef struct packed {
    logic [DATA_W-1:0] key_mask;
    logic [DATA_W-1:0] threshold;
    logic [DATA_W-1:0] code_released;
    logic [DATA_W-1:0] code_up;
    logic [DATA_W-1:0] code_down;
    logic [DATA_W-1:0] code_both;
    logic [DATA_W-1:0] max_volume;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] last_masked;
    logic [DATA_W-1:0] stable_count;
    logic [DATA_W-1:0] keys_before;
    logic [DATA_W-1:0] keys_now;
    logic [DATA_W-1:0] volume;
  } key_state_t;

  typedef struct packed {
    key_event_e        key_event;
    logic [DATA_W-1:0] volume_now;
    logic              store_request;
  } result_t;

endpackage

FILE: sv/vkdd_step.sv
// Next-state and result logic for one debounced port sample.
module vkdd_step (
  input  vkdd_pkg::cfg_t                 cfg_i,
  input  vkdd_pkg::key_state_t           state_i,
  input  logic [vkdd_pkg::DATA_W-1:0]    sample_i,
  output vkdd_pkg::key_state_t           state_o,
  output vkdd_pkg::result_t              result_o
);

  logic [vkdd_pkg::DATA_W-1:0] masked;
  logic [vkdd_pkg::DATA_W-1:0] count;
  logic                        accept;
  logic                        released;

  always_comb begin
    masked = sample_i & cfg_i.key_mask & vkdd_pkg::PortMask;

    if (masked == state_i.last_masked) begin
      count = (state_i.stable_count == {vkdd_pkg::DATA_W{1'b1}}) ?
              state_i.stable_count : state_i.stable_count + 1'b1;
    end else begin
      count = '0;
    end
    accept = (count >= cfg_i.threshold);

    state_o             = state_i;
    state_o.last_masked = masked;
    state_o.stable_count = count;

    result_o.key_event     = vkdd_pkg::EV_NONE;
    result_o.store_request = 1'b0;
    released               = 1'b0;

    if (accept) begin
      state_o.stable_count = '0;
      state_o.keys_before  = state_i.keys_now;
      // chord holds until the released pattern is seen
      if (state_i.keys_now != cfg_i.code_both || masked == cfg_i.code_released) begin
        state_o.keys_now = masked;
      end
      released = (state_o.keys_now == cfg_i.code_released);

      if (released && state_i.keys_now == cfg_i.code_up &&
          state_i.volume < cfg_i.max_volume) begin
        state_o.volume         = state_i.volume + 1'b1;
        result_o.key_event     = vkdd_pkg::EV_UP;
        result_o.store_request = 1'b1;
      end else if (released && state_i.keys_now == cfg_i.code_down &&
                   state_i.volume != '0) begin
        state_o.volume         = state_i.volume - 1'b1;
        result_o.key_event     = vkdd_pkg::EV_DOWN;
        result_o.store_request = 1'b1;
      end else if (released && state_i.keys_now == cfg_i.code_both) begin
        result_o.key_event = vkdd_pkg::EV_ALBUM;
      end
    end

    result_o.volume_now = state_o.volume;
  end

endmodule

FILE: sv/volume_key_debounce_decoder.sv
// Top level of the volume key debounce decoder: registers, handshakes and state.
//
// Usage: one raw port sample per beat on the input channel (in_valid_i /
// in_ready_o, port_sample_i). Each sample gives exactly one result beat on
// the output channel (out_valid_o / out_ready_i): key_event_o (none, up,
// down, album), volume_now_o and store_request_o, which asks for the new
// volume to be persisted.
// Flow: a sample lands in the input register on its accepting edge; its
// result is then registered in the result register and offered from there.
// Throughput: one sample per cycle while out_ready_i is high; the whole
// debounce and volume update is a single short compare/increment path
// between the input register and the result register.
// Stall: when the receiver holds out_ready_i low, the result holds, the
// input register keeps one more sample, and in_ready_o then drops.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// always ready; the user must keep it written only while idle, which the
// block does not enforce. Unknown indexes are ignored. Reset: registers go
// to their reset values, debounce state and volume to zero, both channels empty.
module volume_key_debounce_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vkdd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vkdd_pkg::DATA_W-1:0]       cfg_data_i,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [vkdd_pkg::DATA_W-1:0]       port_sample_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        key_event_o,
  output logic [vkdd_pkg::DATA_W-1:0]       volume_now_o,
  output logic                              store_request_o
);

  vkdd_pkg::cfg_t                 cfg_q;
  vkdd_pkg::key_state_t           state_q, state_d;
  vkdd_pkg::result_t              result_q, result_d;
  logic [vkdd_pkg::DATA_W-1:0]    sample_q;
  logic                           in_full_q;
  logic                           out_full_q;
  logic                           advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_full_q && (!out_full_q || out_ready_i);
  assign in_ready_o  = !in_full_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_mask      <= 8'd255;
      cfg_q.threshold     <= 8'd10;
      cfg_q.code_released <= 8'd0;
      cfg_q.code_up       <= 8'd1;
      cfg_q.code_down     <= 8'd2;
      cfg_q.code_both     <= 8'd3;
      cfg_q.max_volume    <= 8'd15;
    end else if (cfg_valid_i) begin
      unique case (vkdd_pkg::cfg_reg_e'(cfg_index_i))
        vkdd_pkg::REG_KEY_MASK:  cfg_q.key_mask      <= cfg_data_i;
        vkdd_pkg::REG_THRESHOLD: cfg_q.threshold     <= cfg_data_i;
        vkdd_pkg::REG_CODE_REL:  cfg_q.code_released <= cfg_data_i;
        vkdd_pkg::REG_CODE_UP:   cfg_q.code_up       <= cfg_data_i;
        vkdd_pkg::REG_CODE_DOWN: cfg_q.code_down     <= cfg_data_i;
        vkdd_pkg::REG_CODE_BOTH: cfg_q.code_both     <= cfg_data_i;
        vkdd_pkg::REG_MAX_VOL:   cfg_q.max_volume    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vkdd_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .sample_i (sample_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_ready_o) begin
      in_full_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= port_sample_i;
    end
  end

  // debounce state moves only when a sample is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else if (advance) begin
      out_full_q <= 1'b1;
    end else if (out_ready_i) begin
      out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_full_q;
  assign key_event_o     = result_q.key_event;
  assign volume_now_o    = result_q.volume_now;
  assign store_request_o = result_q.store_request;

endmodule

FILE: tb/sv/tb_volume_key_debounce_decoder.sv
// Self-checking testbench for the volume key debounce decoder: random key traffic vs. a predictor.
module tb_volume_key_debounce_decoder;

  typedef logic [vkdd_pkg::DATA_W-1:0] byte_t;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned NUM_PHASES  = 14;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  vkdd_pkg::cfg_reg_e cfg_index = vkdd_pkg::REG_KEY_MASK;
  byte_t              cfg_data = '0;

  logic     in_valid = 1'b0;
  logic     in_ready;
  byte_t    port_sample = '0;

  logic     out_valid;
  logic     out_ready = 1'b0;
  logic [1:0] key_event;
  byte_t    volume_now;
  logic     store_request;

  // Shadow registers and debounce state of the predictor.
  vkdd_pkg::cfg_t reg_shadow = '{key_mask: 8'hFF, threshold: 8'd10, code_released: 8'd0,
                                 code_up: 8'd1, code_down: 8'd2, code_both: 8'd3,
                                 max_volume: 8'd15};
  vkdd_pkg::key_state_t key_state = '0;

  byte_t             port_samples_q[$];
  vkdd_pkg::result_t predicted_events_q[$];

  int unsigned fail_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        rx_hold = 1'b0;

  always #5 clk = ~clk;

  volume_key_debounce_decoder u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .port_sample_i   (port_sample),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .key_event_o     (key_event),
    .volume_now_o    (volume_now),
    .store_request_o (store_request)
  );

  // One debounce tick: updates key_state and returns the event it yields.
  function automatic vkdd_pkg::result_t decode_key_tick(byte_t raw);
    byte_t             masked;
    logic              released;
    vkdd_pkg::result_t res;
    masked = raw & vkdd_pkg::PortMask & reg_shadow.key_mask;
    res.key_event = vkdd_pkg::EV_NONE;
    res.store_request = 1'b0;
    if (masked == key_state.last_masked) begin
      if (key_state.stable_count != 8'hFF) key_state.stable_count = key_state.stable_count + 1'b1;
    end else begin
      key_state.stable_count = '0;
    end
    key_state.last_masked = masked;
    if (key_state.stable_count >= reg_shadow.threshold) begin
      key_state.stable_count = '0;
      key_state.keys_before = key_state.keys_now;
      // a chord stays latched until the released pattern shows up
      if (key_state.keys_before != reg_shadow.code_both || masked == reg_shadow.code_released)
        key_state.keys_now = masked;
      released = (key_state.keys_now == reg_shadow.code_released);
      if (released && key_state.keys_before == reg_shadow.code_up &&
          key_state.volume < reg_shadow.max_volume) begin
        key_state.volume = key_state.volume + 1'b1;
        res.key_event = vkdd_pkg::EV_UP;
        res.store_request = 1'b1;
      end else if (released && key_state.keys_before == reg_shadow.code_down &&
                   key_state.volume != '0) begin
        key_state.volume = key_state.volume - 1'b1;
        res.key_event = vkdd_pkg::EV_DOWN;
        res.store_request = 1'b1;
      end else if (released && key_state.keys_before == reg_shadow.code_both) begin
        res.key_event = vkdd_pkg::EV_ALBUM;
      end
    end
    res.volume_now = key_state.volume;
    return res;
  endfunction

  // Sample driver: predicts on every accepted beat, then offers the next one.
  always @(posedge clk or negedge rst_n) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_events_q.push_back(decode_key_tick(port_sample));
      if (in_valid && !in_ready) begin
        // beat still pending, payload holds
      end else if (port_samples_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid    <= 1'b1;
        port_sample <= port_samples_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk or negedge rst_n) begin : monitor
    vkdd_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_events_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("unexpected result beat: event %0d volume %0d store %0b",
                     key_event, volume_now, store_request);
        end else begin
          want = predicted_events_q.pop_front();
          if (key_event !== want.key_event || volume_now !== want.volume_now ||
              store_request !== want.store_request) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("mismatch: event %0d exp %0d, volume %0d exp %0d, store %0b exp %0b",
                       key_event, want.key_event, volume_now, want.volume_now,
                       store_request, want.store_request);
          end
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(vkdd_pkg::cfg_reg_e idx, byte_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      vkdd_pkg::REG_KEY_MASK:  reg_shadow.key_mask = val;
      vkdd_pkg::REG_THRESHOLD: reg_shadow.threshold = val;
      vkdd_pkg::REG_CODE_REL:  reg_shadow.code_released = val;
      vkdd_pkg::REG_CODE_UP:   reg_shadow.code_up = val;
      vkdd_pkg::REG_CODE_DOWN: reg_shadow.code_down = val;
      vkdd_pkg::REG_CODE_BOTH: reg_shadow.code_both = val;
      vkdd_pkg::REG_MAX_VOL:   reg_shadow.max_volume = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (port_samples_q.size() != 0 || in_valid || predicted_events_q.size() != 0);
  endtask

  // Holds a key pattern long enough to be accepted (sometimes just short of it);
  // bits outside the key mask toggle freely.
  function automatic int hold_key(byte_t code);
    int run_len;
    run_len = $urandom_range(reg_shadow.threshold + 2, reg_shadow.threshold);
    if (run_len == 0) run_len = 1;
    repeat (run_len)
      port_samples_q.push_back(code | (byte_t'($urandom) & ~reg_shadow.key_mask));
    return run_len;
  endfunction

  // Mostly press/release sequences, some raw noise in between.
  function automatic void feed_phase(int n_items, int up_pct);
    int    made;
    int    burst;
    byte_t code;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(99) < 15) begin
        burst = $urandom_range(3, 1);
        repeat (burst) port_samples_q.push_back(byte_t'($urandom));
        made += burst;
      end else begin
        if ($urandom_range(99) < up_pct) code = reg_shadow.code_up;
        else if ($urandom_range(2) == 0) code = reg_shadow.code_both;
        else code = reg_shadow.code_down;
        made += hold_key(code);
        // a single key during a chord must not break the latch
        if (code == reg_shadow.code_both && $urandom_range(2) == 0)
          made += hold_key(($urandom_range(1) != 0) ? reg_shadow.code_up : reg_shadow.code_down);
        made += hold_key(reg_shadow.code_released);
      end
    end
  endfunction

  function automatic byte_t pick_code(byte_t mask);
    case ($urandom_range(4))
      0: return '0;
      1: return mask;
      default: return byte_t'($urandom) & mask;
    endcase
  endfunction

  initial begin : stimulus
    vkdd_pkg::cfg_t phase_cfg;
    int   n_items;
    int   up_pct;

    send_idle_pct <= 12;
    recv_idle_pct <= 65;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every tick accepted with the reset codes.
    write_reg(vkdd_pkg::REG_THRESHOLD, 8'd0);
    write_reg(vkdd_pkg::REG_UNUSED, byte_t'($urandom));
    @(negedge clk);
    port_samples_q = {8'h01, 8'h00,           // up then release
                      8'h02, 8'h00,           // down back to zero
                      8'h02, 8'h00,           // down at zero: no event
                      8'h03, 8'h01, 8'h02, 8'h00, // chord, locked, album on release
                      8'hFF, 8'h00, 8'hAA, 8'h55};
    wait_drained();
    write_reg(vkdd_pkg::REG_MAX_VOL, 8'd1);
    @(negedge clk);
    port_samples_q = {8'h01, 8'h00, 8'h01, 8'h00}; // second up stops at max
    wait_drained();
    write_reg(vkdd_pkg::REG_MAX_VOL, 8'd0);
    @(negedge clk);
    port_samples_q = {8'h01, 8'h00, 8'h02, 8'h00}; // volume above max: only down moves
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct <= (p < 5) ? 12 : (p < 10) ? 65 : 0;
      recv_idle_pct <= (p < 5) ? 65 : (p < 10) ? 12 : 0;
      phase_cfg.key_mask      = 8'hFF;
      phase_cfg.threshold     = byte_t'($urandom_range(4));
      phase_cfg.code_released = 8'd0;
      phase_cfg.code_up       = 8'd1;
      phase_cfg.code_down     = 8'd2;
      phase_cfg.code_both     = 8'd3;
      phase_cfg.max_volume    = 8'd15;
      n_items = 50;
      up_pct  = 40;
      case (p)
        0: ;
        1: begin // climb all the way to the top and saturate
          phase_cfg.threshold  = 8'd0;
          phase_cfg.max_volume = 8'd120;
          up_pct  = 100;
          n_items = 550;
        end
        2: begin
          phase_cfg.max_volume = 8'd3;
          up_pct = 30;
        end
        3: begin
          phase_cfg.key_mask      = 8'h00;
          phase_cfg.code_released = pick_code(8'hFF);
          phase_cfg.code_up       = pick_code(8'hFF);
          phase_cfg.code_down     = pick_code(8'hFF);
          phase_cfg.code_both     = pick_code(8'hFF);
        end
        4: begin
          phase_cfg.threshold = 8'hFF;
          n_items = 300;
        end
        5: begin // one code for all three keys, check order decides
          phase_cfg.code_up   = byte_t'($urandom_range(255, 1));
          phase_cfg.code_down = phase_cfg.code_up;
          phase_cfg.code_both = phase_cfg.code_up;
          phase_cfg.max_volume = pick_code(8'hFF);
        end
        13: begin
          phase_cfg.code_released = 8'hFF;
          phase_cfg.code_up       = 8'h00;
          phase_cfg.code_down     = 8'h7F;
          phase_cfg.code_both     = 8'h80;
          phase_cfg.max_volume    = 8'hFF;
        end
        default: begin
          phase_cfg.key_mask = ($urandom_range(1) != 0) ? byte_t'($urandom)
                                                        : byte_t'(8'h03 << $urandom_range(6));
          phase_cfg.code_released = pick_code(phase_cfg.key_mask);
          phase_cfg.code_up       = pick_code(phase_cfg.key_mask);
          phase_cfg.code_down     = pick_code(phase_cfg.key_mask);
          phase_cfg.code_both     = pick_code(phase_cfg.key_mask);
          phase_cfg.max_volume    = pick_code(8'hFF);
        end
      endcase
      write_reg(vkdd_pkg::REG_KEY_MASK,  phase_cfg.key_mask);
      write_reg(vkdd_pkg::REG_THRESHOLD, phase_cfg.threshold);
      write_reg(vkdd_pkg::REG_CODE_REL,  phase_cfg.code_released);
      write_reg(vkdd_pkg::REG_CODE_UP,   phase_cfg.code_up);
      write_reg(vkdd_pkg::REG_CODE_DOWN, phase_cfg.code_down);
      write_reg(vkdd_pkg::REG_CODE_BOTH, phase_cfg.code_both);
      write_reg(vkdd_pkg::REG_MAX_VOL,   phase_cfg.max_volume);
      @(negedge clk);
      feed_phase(n_items, up_pct);
      // receiver backs off long enough for the input side to fill and stall
      if (p == 2) begin
        fork
          begin
            @(posedge clk);
            rx_hold <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    fail_cnt += predicted_events_q.size();
    if (fail_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
